FILE: hdl/amb_pkg.sv
// Package: codes, constants and types shared by the modem bring-up sequencer.
`default_nettype none
package amb_pkg;

    localparam int CNT_W = 15;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // command codes
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_PROBE   = 3'd1;
    localparam logic [2:0] CMD_VERSION = 3'd2;
    localparam logic [2:0] CMD_MODE_Q  = 3'd3;
    localparam logic [2:0] CMD_AP_Q    = 3'd4;
    localparam logic [2:0] CMD_SET_STA = 3'd5;
    localparam logic [2:0] CMD_JOIN    = 3'd6;
    localparam logic [2:0] CMD_IP_Q    = 3'd7;

    // events
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_SEND    = 3'd1;
    localparam logic [2:0] EV_PASS    = 3'd2;
    localparam logic [2:0] EV_FAIL    = 3'd3;
    localparam logic [2:0] EV_NOAP    = 3'd4;
    localparam logic [2:0] EV_RESTART = 3'd5;

    // fail reasons
    localparam logic [3:0] FR_NONE      = 4'd0;
    localparam logic [3:0] FR_FLASH     = 4'd1;
    localparam logic [3:0] FR_SSID      = 4'd2;
    localparam logic [3:0] FR_TX        = 4'd3;
    localparam logic [3:0] FR_TIMEOUT   = 4'd4;
    localparam logic [3:0] FR_JOIN_ERR  = 4'd5;
    localparam logic [3:0] FR_IP_ERR    = 4'd6;
    localparam logic [3:0] FR_AT_ERR    = 4'd7;
    localparam logic [3:0] FR_IP_EMPTY  = 4'd8;

    // line classes
    localparam logic [2:0] LC_INVALID = 3'd1;
    localparam logic [2:0] LC_AP      = 3'd2;
    localparam logic [2:0] LC_IP      = 3'd3;
    localparam logic [2:0] LC_GOT_IP  = 3'd4;
    localparam logic [2:0] LC_OK      = 3'd5;
    localparam logic [2:0] LC_ERROR   = 3'd6;

    // quoted field status
    localparam logic [1:0] QS_EMPTY = 2'd1;
    localparam logic [1:0] QS_FULL  = 2'd2;

    // register indexes
    localparam logic [2:0] RI_JOIN_CFG   = 3'd0;
    localparam logic [2:0] RI_JOIN_VALID = 3'd1;
    localparam logic [2:0] RI_CMD_TO     = 3'd2;
    localparam logic [2:0] RI_JOIN_TO    = 3'd3;
    localparam logic [2:0] RI_PASS_HOLD  = 3'd4;
    localparam logic [2:0] RI_FAIL_HOLD  = 3'd5;

    typedef struct packed {
        logic             join_configured;
        logic             join_command_valid;
        logic [CNT_W-1:0] command_timeout_ticks;
        logic [CNT_W-1:0] join_timeout_ticks;
        logic [CNT_W-1:0] pass_hold_ticks;
        logic [CNT_W-1:0] fail_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] line_class;
        logic [1:0] quote_status;
        logic       tx_ready;
    } item_t;

    typedef struct packed {
        logic [2:0]       awaited_cmd;
        logic [2:0]       next_cmd;
        logic [CNT_W-1:0] wait_count;
        logic [CNT_W-1:0] hold_count;
        logic             station_joined;
        logic             address_obtained;
        logic             address_nonempty;
    } seq_state_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] command_code;
        logic [3:0] fail_reason;
        logic [2:0] waiting_command;
    } result_t;

    localparam seq_state_t SEQ_RESET = '{
        awaited_cmd:      CMD_NONE,
        next_cmd:         CMD_PROBE,
        wait_count:       '0,
        hold_count:       '0,
        station_joined:   1'b0,
        address_obtained: 1'b0,
        address_nonempty: 1'b0
    };

endpackage
`default_nettype wire

FILE: hdl/amb_step.sv
// Next-state and result logic for one word of the bring-up sequencer.
`default_nettype none
module amb_step
    import amb_pkg::*;
(
    input  var cfg_t       cfg,
    input  var item_t      item,
    input  var seq_state_t cur,
    output seq_state_t     nxt,
    output result_t        res
);

    logic [CNT_W-1:0] pass_hold;
    logic [CNT_W-1:0] fail_hold;
    logic [CNT_W-1:0] limit;
    logic [2:0]       ev;
    logic [2:0]       ec;
    logic [3:0]       er;

    assign pass_hold = (cfg.pass_hold_ticks == '0) ? CNT_W'(1) : cfg.pass_hold_ticks;
    assign fail_hold = (cfg.fail_hold_ticks == '0) ? CNT_W'(1) : cfg.fail_hold_ticks;
    assign limit     = (cur.awaited_cmd == CMD_JOIN) ? cfg.join_timeout_ticks
                                                     : cfg.command_timeout_ticks;

    always_comb
    begin
        nxt = cur;
        ev  = EV_NONE;
        ec  = CMD_NONE;
        er  = FR_NONE;
        if (item.mode)
        begin
            if (item.line_class == LC_INVALID)
            begin
                nxt.awaited_cmd = CMD_NONE;
                nxt.next_cmd    = CMD_NONE;
                nxt.hold_count  = fail_hold;
                ev = EV_FAIL;
                er = FR_FLASH;
            end
            else
            begin
                if (item.line_class == LC_AP)
                    nxt.station_joined = 1'b1;
                if (item.line_class == LC_IP)
                begin
                    if (item.quote_status == QS_EMPTY)
                        nxt.address_nonempty = 1'b0;
                    else if (item.quote_status == QS_FULL)
                        nxt.address_nonempty = 1'b1;
                    nxt.address_obtained = nxt.address_nonempty;
                end
                if (item.line_class == LC_GOT_IP)
                    nxt.address_obtained = 1'b1;
                if (cur.awaited_cmd != CMD_NONE && item.line_class == LC_OK)
                begin
                    nxt.awaited_cmd = CMD_NONE;
                    unique case (cur.awaited_cmd)
                        CMD_PROBE:   nxt.next_cmd = CMD_VERSION;
                        CMD_VERSION: nxt.next_cmd = CMD_MODE_Q;
                        CMD_MODE_Q:  nxt.next_cmd = CMD_AP_Q;
                        CMD_AP_Q:
                        begin
                            if (cur.station_joined)
                                nxt.next_cmd = CMD_IP_Q;
                            else if (cfg.join_configured)
                                nxt.next_cmd = CMD_SET_STA;
                            else
                            begin
                                nxt.next_cmd   = CMD_NONE;
                                nxt.hold_count = pass_hold;
                                ev = EV_NOAP;
                            end
                        end
                        CMD_SET_STA: nxt.next_cmd = CMD_JOIN;
                        CMD_JOIN:
                        begin
                            if (cur.address_obtained)
                                nxt.station_joined = 1'b1;
                            nxt.next_cmd = CMD_IP_Q;
                        end
                        default:
                        begin
                            nxt.next_cmd = CMD_NONE;
                            if (cur.address_nonempty)
                            begin
                                nxt.hold_count = pass_hold;
                                ev = EV_PASS;
                            end
                            else
                            begin
                                nxt.hold_count = fail_hold;
                                ev = EV_FAIL;
                                er = FR_IP_EMPTY;
                            end
                        end
                    endcase
                end
                else if (cur.awaited_cmd != CMD_NONE && item.line_class == LC_ERROR)
                begin
                    nxt.awaited_cmd = CMD_NONE;
                    if (cur.awaited_cmd == CMD_AP_Q && cfg.join_configured)
                        nxt.next_cmd = CMD_SET_STA;
                    else
                    begin
                        nxt.next_cmd = CMD_NONE;
                        if (cur.awaited_cmd == CMD_AP_Q)
                        begin
                            nxt.hold_count = pass_hold;
                            ev = EV_NOAP;
                        end
                        else
                        begin
                            nxt.hold_count = fail_hold;
                            ev = EV_FAIL;
                            if (cur.awaited_cmd == CMD_JOIN)
                                er = FR_JOIN_ERR;
                            else if (cur.awaited_cmd == CMD_IP_Q)
                                er = FR_IP_ERR;
                            else
                                er = FR_AT_ERR;
                        end
                    end
                end
            end
        end
        else
        begin
            if (cur.awaited_cmd != CMD_NONE)
            begin
                if (cur.wait_count != CNT_MAX)
                    nxt.wait_count = cur.wait_count + CNT_W'(1);
                if (nxt.wait_count >= limit)
                begin
                    nxt.awaited_cmd = CMD_NONE;
                    nxt.next_cmd    = CMD_NONE;
                    nxt.hold_count  = fail_hold;
                    ev = EV_FAIL;
                    er = FR_TIMEOUT;
                end
            end
            if (nxt.awaited_cmd == CMD_NONE && nxt.next_cmd != CMD_NONE)
            begin
                nxt.next_cmd = CMD_NONE;
                if (cur.next_cmd == CMD_JOIN && !cfg.join_command_valid)
                begin
                    nxt.hold_count = fail_hold;
                    ev = EV_FAIL;
                    er = FR_SSID;
                end
                else if (!item.tx_ready)
                begin
                    nxt.hold_count = fail_hold;
                    ev = EV_FAIL;
                    er = FR_TX;
                end
                else
                begin
                    nxt.awaited_cmd = cur.next_cmd;
                    nxt.wait_count  = '0;
                    ev = EV_SEND;
                    ec = cur.next_cmd;
                end
            end
            else if (nxt.awaited_cmd == CMD_NONE && nxt.hold_count != '0)
            begin
                if (nxt.hold_count <= CNT_W'(1))
                begin
                    nxt = SEQ_RESET;
                    if (ev == EV_NONE)
                        ev = EV_RESTART;
                end
                else
                    nxt.hold_count = nxt.hold_count - CNT_W'(1);
            end
        end
    end

    assign res.event_res       = ev;
    assign res.command_code    = ec;
    assign res.fail_reason     = (ev == EV_FAIL) ? er : FR_NONE;
    assign res.waiting_command = nxt.awaited_cmd;

endmodule
`default_nettype wire

FILE: hdl/at_modem_bringup_sequencer.sv
// Top level: modem bring-up sequencer with register port and word pipeline.
//
// Input channel (in_valid/in_stall) carries one word per tick or received
// response line: mode, line_class, quote_status, tx_ready. Output channel
// (out_valid/out_stall) returns exactly one word per input word: event_res,
// command_code, fail_reason, waiting_command.
// An accepted word is loaded into the input register; when it advances, the
// sequencer state and the output register are written from it together.
// Throughput is one word per cycle while the output is not stalled; the step
// logic is a single pass.
// When out_stall holds a full output register, the input register stays full
// and in_stall rises; no word is dropped or duplicated.
// Reset clears the sequence (next command probe, nothing awaited) and loads
// register defaults. Registers sit at byte addresses 0,4,..,20 and are to be
// written only while no word is in flight.
`default_nettype none
module at_modem_bringup_sequencer
    import amb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [2:0]  line_class,
    input  wire logic [1:0]  quote_status,
    input  wire logic        tx_ready,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  event_res,
    output logic      [2:0]  command_code,
    output logic      [3:0]  fail_reason,
    output logic      [2:0]  waiting_command
);

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       in_vld_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_vld_reg;
    logic       adv;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.join_configured       <= 1'b0;
            cfg_reg.join_command_valid    <= 1'b1;
            cfg_reg.command_timeout_ticks <= CNT_W'(2500);
            cfg_reg.join_timeout_ticks    <= CNT_W'(20000);
            cfg_reg.pass_hold_ticks       <= CNT_W'(10000);
            cfg_reg.fail_hold_ticks       <= CNT_W'(3000);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                RI_JOIN_CFG:   cfg_reg.join_configured       <= pwdata[0];
                RI_JOIN_VALID: cfg_reg.join_command_valid    <= pwdata[0];
                RI_CMD_TO:     cfg_reg.command_timeout_ticks <= pwdata[CNT_W-1:0];
                RI_JOIN_TO:    cfg_reg.join_timeout_ticks    <= pwdata[CNT_W-1:0];
                RI_PASS_HOLD:  cfg_reg.pass_hold_ticks       <= pwdata[CNT_W-1:0];
                RI_FAIL_HOLD:  cfg_reg.fail_hold_ticks       <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            RI_JOIN_CFG:   prdata = {31'd0, cfg_reg.join_configured};
            RI_JOIN_VALID: prdata = {31'd0, cfg_reg.join_command_valid};
            RI_CMD_TO:     prdata = {17'd0, cfg_reg.command_timeout_ticks};
            RI_JOIN_TO:    prdata = {17'd0, cfg_reg.join_timeout_ticks};
            RI_PASS_HOLD:  prdata = {17'd0, cfg_reg.pass_hold_ticks};
            RI_FAIL_HOLD:  prdata = {17'd0, cfg_reg.fail_hold_ticks};
            default:       prdata = 32'd0;
        endcase
    end

    assign adv      = in_vld_reg & (~out_vld_reg | ~out_stall);
    assign in_stall = in_vld_reg & ~adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.mode         <= mode;
            item_reg.line_class   <= line_class;
            item_reg.quote_status <= quote_status;
            item_reg.tx_ready     <= tx_ready;
        end
    end

    amb_step u_step (
        .cfg  (cfg_reg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_RESET;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            state_reg   <= state_next;
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign out_valid       = out_vld_reg;
    assign event_res       = res_reg.event_res;
    assign command_code    = res_reg.command_code;
    assign fail_reason     = res_reg.fail_reason;
    assign waiting_command = res_reg.waiting_command;

endmodule
`default_nettype wire

FILE: hdl/amb_checker.sv
// Port-level checks for the modem bring-up sequencer, bound to the top level.
`default_nettype none
module amb_checker
    import amb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] event_res,
    input wire logic [2:0] command_code,
    input wire logic [3:0] fail_reason,
    input wire logic [2:0] waiting_command
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
            && $stable(command_code) && $stable(fail_reason) && $stable(waiting_command))
        else $error("stalled output word changed");

    a_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_SEND |->
            command_code != CMD_NONE && waiting_command == command_code)
        else $error("send word without matching awaited command");

    a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_SEND |-> command_code == CMD_NONE)
        else $error("command code outside a send word");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res == EV_FAIL) == (fail_reason != FR_NONE))
        else $error("fail reason does not match event");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_FAIL || event_res == EV_PASS
            || event_res == EV_NOAP || event_res == EV_RESTART)
            |-> waiting_command == CMD_NONE)
        else $error("command still awaited after end of sequence");

endmodule

bind at_modem_bringup_sequencer amb_checker u_amb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_res       (event_res),
    .command_code    (command_code),
    .fail_reason     (fail_reason),
    .waiting_command (waiting_command)
);
`default_nettype wire
